// File: design/utrb_pkg.sv
// ----------------------------------------------------------------------------
// utrb_pkg
// Shared types and constants of the serial port ring buffer engine: command
// and status codes, the classified operation and the result beat.
// ----------------------------------------------------------------------------
package utrb_pkg;

    // default ring depths
    localparam int TX_DEPTH_DEF = 64;
    localparam int RX_DEPTH_DEF = 64;

    // longest host read that can be answered
    localparam logic [6:0] MAX_READ_LEN = 7'd64;

    // stream payload widths
    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = 2;

    // input command codes
    typedef enum logic [1:0] {
        CMD_HOST_WRITE = 2'd0,
        CMD_TX_READY   = 2'd1,
        CMD_RX_BYTE    = 2'd2,
        CMD_HOST_READ  = 2'd3
    } cmd_t;

    // operation kinds handed to the back end
    typedef enum logic [1:0] {
        OP_TX_WRITE = 2'd0,
        OP_TX_POP   = 2'd1,
        OP_RX_PUSH  = 2'd2,
        OP_RX_READ  = 2'd3
    } op_kind_t;

    // result status codes
    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_NO_ROOM = 2'd1,
        STATUS_SHORT   = 2'd2
    } status_t;

    // classified operation
    typedef struct packed {
        op_kind_t   kind;
        logic [7:0] data_byte;
        logic       block_first;
        logic [6:0] block_count;
        logic       zero_len;
        logic       oversize;
    } op_t;

    // one result beat
    typedef struct packed {
        status_t    status;
        logic [7:0] tx_byte;
        logic       tx_strobe;
        logic       tx_irq_enable;
        logic [7:0] rx_byte;
        logic       rx_byte_valid;
        logic       rx_overflow;
        logic       last;
    } res_t;

endpackage

// File: design/utrb_ram.sv
// ----------------------------------------------------------------------------
// utrb_ram
// Generic simple dual port RAM: one write port, one read port with
// registered read data that holds while no read is issued.
// ----------------------------------------------------------------------------
module utrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/utrb_front.sv
// ----------------------------------------------------------------------------
// utrb_front
// Accepts input beats, classifies them into operations and holds them in a
// two-entry queue that decouples the input side from the ring engine.
// ----------------------------------------------------------------------------
module utrb_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [utrb_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [utrb_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                           op_valid,
    input  logic                           op_ready,
    output utrb_pkg::op_t                  op
);
    import utrb_pkg::*;

    op_t        q_reg [2];
    op_t        q_next [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    op_t        op_in;
    cmd_t       cmd;
    logic       push;
    logic       pop;

    // classify the incoming beat
    always_comb
    begin
        cmd               = cmd_t'(s_tuser[1:0]);
        op_in.data_byte   = s_tdata[7:0];
        op_in.block_count = s_tdata[14:8];
        op_in.block_first = s_tuser[2];
        op_in.zero_len    = (s_tdata[14:8] == 7'd0);
        op_in.oversize    = (s_tdata[14:8] > MAX_READ_LEN);
        case (cmd)
            CMD_HOST_WRITE: op_in.kind = OP_TX_WRITE;
            CMD_TX_READY:   op_in.kind = OP_TX_POP;
            CMD_RX_BYTE:    op_in.kind = OP_RX_PUSH;
            CMD_HOST_READ:  op_in.kind = OP_RX_READ;
            default:        op_in.kind = OP_TX_WRITE;
        endcase
    end

    assign s_tready = (count_reg != 2'd2);
    assign op_valid = (count_reg != 2'd0);
    assign op       = q_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = op_valid && op_ready;

    // queue bookkeeping
    always_comb
    begin
        q_next      = q_reg;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            q_next[wr_ptr_reg] = op_in;
            wr_ptr_next        = ~wr_ptr_reg;
        end
        if (pop)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    // queue payload
    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    // queue control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: design/utrb_back.sv
// ----------------------------------------------------------------------------
// utrb_back
// Ring engine: owns the transmit and receive rings, carries out one queued
// operation at a time and drives the registered result beat.
// ----------------------------------------------------------------------------
module utrb_back #(
    parameter int TX_DEPTH = utrb_pkg::TX_DEPTH_DEF,
    parameter int RX_DEPTH = utrb_pkg::RX_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           op_valid,
    output logic           op_ready,
    input  utrb_pkg::op_t  op,
    output logic           res_valid,
    input  logic           res_ready,
    output utrb_pkg::res_t res
);
    import utrb_pkg::*;

    localparam int TAW = $clog2(TX_DEPTH);
    localparam int RAW = $clog2(RX_DEPTH);
    localparam int TFW = $clog2(TX_DEPTH + 1);
    localparam int RFW = $clog2(RX_DEPTH + 1);
    localparam int TSW = ((TFW > 7) ? TFW : 7) + 1;
    localparam int RSW = (RFW > 7) ? RFW : 7;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TX_DATA,
        ST_RX_RD,
        ST_RX_DATA
    } state_t;

    state_t         state_reg, state_next;
    logic [TAW-1:0] tx_wr_ptr_reg, tx_wr_ptr_next;
    logic [TAW-1:0] tx_rd_ptr_reg, tx_rd_ptr_next;
    logic [TFW-1:0] tx_fill_reg, tx_fill_next;
    logic           send_active_reg, send_active_next;
    logic [6:0]     block_remaining_reg, block_remaining_next;
    logic           block_rejected_reg, block_rejected_next;
    logic [RAW-1:0] rx_wr_ptr_reg, rx_wr_ptr_next;
    logic [RAW-1:0] rx_rd_ptr_reg, rx_rd_ptr_next;
    logic [RFW-1:0] rx_fill_reg, rx_fill_next;
    logic [6:0]     rx_remaining_reg, rx_remaining_next;
    logic           res_valid_reg, res_valid_next;
    res_t           res_reg, res_next;

    logic           tx_we, tx_re, rx_we, rx_re;
    logic [7:0]     tx_rd_data, rx_rd_data;
    logic           res_free;
    logic           tx_room;
    logic           rx_short;

    // transmit ring storage
    utrb_ram #(
        .WIDTH (8),
        .DEPTH (TX_DEPTH),
        .AW    (TAW)
    ) u_tx_ram (
        .clk     (clk),
        .wr_en   (tx_we),
        .wr_addr (tx_wr_ptr_reg),
        .wr_data (op.data_byte),
        .rd_en   (tx_re),
        .rd_addr (tx_rd_ptr_reg),
        .rd_data (tx_rd_data)
    );

    // receive ring storage
    utrb_ram #(
        .WIDTH (8),
        .DEPTH (RX_DEPTH),
        .AW    (RAW)
    ) u_rx_ram (
        .clk     (clk),
        .wr_en   (rx_we),
        .wr_addr (rx_wr_ptr_reg),
        .wr_data (op.data_byte),
        .rd_en   (rx_re),
        .rd_addr (rx_rd_ptr_reg),
        .rd_data (rx_rd_data)
    );

    assign res_free = !res_valid_reg || res_ready;
    assign tx_room  = (TSW'(tx_fill_reg) + TSW'(op.block_count)) <= TSW'(TX_DEPTH);
    assign rx_short = RSW'(rx_fill_reg) < RSW'(op.block_count);

    // operation sequencer
    always_comb
    begin
        state_next           = state_reg;
        tx_wr_ptr_next       = tx_wr_ptr_reg;
        tx_rd_ptr_next       = tx_rd_ptr_reg;
        tx_fill_next         = tx_fill_reg;
        send_active_next     = send_active_reg;
        block_remaining_next = block_remaining_reg;
        block_rejected_next  = block_rejected_reg;
        rx_wr_ptr_next       = rx_wr_ptr_reg;
        rx_rd_ptr_next       = rx_rd_ptr_reg;
        rx_fill_next         = rx_fill_reg;
        rx_remaining_next    = rx_remaining_reg;
        res_valid_next       = res_valid_reg && !res_ready;
        res_next             = res_reg;
        tx_we                = 1'b0;
        tx_re                = 1'b0;
        rx_we                = 1'b0;
        rx_re                = 1'b0;
        op_ready             = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                op_ready = res_free;
                if (op_valid && res_free)
                begin
                    res_next      = '0;
                    res_next.last = 1'b1;
                    case (op.kind)
                        OP_TX_WRITE:
                        begin
                            if (op.block_first)
                            begin
                                if (!tx_room)
                                begin
                                    block_rejected_next  = 1'b1;
                                    block_remaining_next = 7'd0;
                                    res_next.status      = STATUS_NO_ROOM;
                                end
                                else
                                begin
                                    block_rejected_next = 1'b0;
                                    send_active_next    = 1'b1;
                                    if (!op.zero_len)
                                    begin
                                        tx_we                = 1'b1;
                                        block_remaining_next = op.block_count - 7'd1;
                                    end
                                    else
                                    begin
                                        block_remaining_next = 7'd0;
                                    end
                                end
                            end
                            else if (block_rejected_reg)
                            begin
                                res_next.status = STATUS_NO_ROOM;
                            end
                            else if (block_remaining_reg != 7'd0)
                            begin
                                tx_we                = 1'b1;
                                block_remaining_next = block_remaining_reg - 7'd1;
                            end
                            if (tx_we)
                            begin
                                tx_fill_next   = tx_fill_reg + TFW'(1);
                                tx_wr_ptr_next = (tx_wr_ptr_reg == TAW'(TX_DEPTH - 1)) ?
                                                 '0 : tx_wr_ptr_reg + TAW'(1);
                            end
                            res_next.tx_irq_enable = send_active_next;
                            res_valid_next         = 1'b1;
                        end
                        OP_TX_POP:
                        begin
                            if (tx_fill_reg == '0)
                            begin
                                send_active_next       = 1'b0;
                                res_next.tx_irq_enable = 1'b0;
                                res_valid_next         = 1'b1;
                            end
                            else
                            begin
                                tx_re          = 1'b1;
                                tx_fill_next   = tx_fill_reg - TFW'(1);
                                tx_rd_ptr_next = (tx_rd_ptr_reg == TAW'(TX_DEPTH - 1)) ?
                                                 '0 : tx_rd_ptr_reg + TAW'(1);
                                state_next     = ST_TX_DATA;
                            end
                        end
                        OP_RX_PUSH:
                        begin
                            if (rx_fill_reg < RFW'(RX_DEPTH))
                            begin
                                rx_we          = 1'b1;
                                rx_fill_next   = rx_fill_reg + RFW'(1);
                                rx_wr_ptr_next = (rx_wr_ptr_reg == RAW'(RX_DEPTH - 1)) ?
                                                 '0 : rx_wr_ptr_reg + RAW'(1);
                            end
                            else
                            begin
                                res_next.rx_overflow = 1'b1;
                            end
                            res_next.tx_irq_enable = send_active_reg;
                            res_valid_next         = 1'b1;
                        end
                        OP_RX_READ:
                        begin
                            if (op.oversize || rx_short)
                            begin
                                res_next.status        = STATUS_SHORT;
                                res_next.tx_irq_enable = send_active_reg;
                                res_valid_next         = 1'b1;
                            end
                            else if (op.zero_len)
                            begin
                                res_next.tx_irq_enable = send_active_reg;
                                res_valid_next         = 1'b1;
                            end
                            else
                            begin
                                rx_remaining_next = op.block_count;
                                state_next        = ST_RX_RD;
                            end
                        end
                        default:
                        begin
                            res_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_TX_DATA:
            begin
                if (res_free)
                begin
                    res_next               = '0;
                    res_next.tx_byte       = tx_rd_data;
                    res_next.tx_strobe     = 1'b1;
                    res_next.tx_irq_enable = send_active_reg;
                    res_next.last          = 1'b1;
                    res_valid_next         = 1'b1;
                    state_next             = ST_IDLE;
                end
            end
            ST_RX_RD:
            begin
                rx_re             = 1'b1;
                rx_fill_next      = rx_fill_reg - RFW'(1);
                rx_remaining_next = rx_remaining_reg - 7'd1;
                rx_rd_ptr_next    = (rx_rd_ptr_reg == RAW'(RX_DEPTH - 1)) ?
                                    '0 : rx_rd_ptr_reg + RAW'(1);
                state_next        = ST_RX_DATA;
            end
            ST_RX_DATA:
            begin
                if (res_free)
                begin
                    res_next               = '0;
                    res_next.rx_byte       = rx_rd_data;
                    res_next.rx_byte_valid = 1'b1;
                    res_next.tx_irq_enable = send_active_reg;
                    res_next.last          = (rx_remaining_reg == 7'd0);
                    res_valid_next         = 1'b1;
                    state_next             = (rx_remaining_reg == 7'd0) ? ST_IDLE : ST_RX_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result payload
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    // state and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= ST_IDLE;
            tx_wr_ptr_reg       <= '0;
            tx_rd_ptr_reg       <= '0;
            tx_fill_reg         <= '0;
            send_active_reg     <= 1'b0;
            block_remaining_reg <= 7'd0;
            block_rejected_reg  <= 1'b0;
            rx_wr_ptr_reg       <= '0;
            rx_rd_ptr_reg       <= '0;
            rx_fill_reg         <= '0;
            rx_remaining_reg    <= 7'd0;
            res_valid_reg       <= 1'b0;
        end
        else
        begin
            state_reg           <= state_next;
            tx_wr_ptr_reg       <= tx_wr_ptr_next;
            tx_rd_ptr_reg       <= tx_rd_ptr_next;
            tx_fill_reg         <= tx_fill_next;
            send_active_reg     <= send_active_next;
            block_remaining_reg <= block_remaining_next;
            block_rejected_reg  <= block_rejected_next;
            rx_wr_ptr_reg       <= rx_wr_ptr_next;
            rx_rd_ptr_reg       <= rx_rd_ptr_next;
            rx_fill_reg         <= rx_fill_next;
            rx_remaining_reg    <= rx_remaining_next;
            res_valid_reg       <= res_valid_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // ring fill never exceeds depth
    a_tx_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tx_fill_reg <= TFW'(TX_DEPTH))
        else $error("transmit ring fill beyond depth");

    a_rx_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rx_fill_reg <= RFW'(RX_DEPTH))
        else $error("receive ring fill beyond depth");

    // a rejected block leaves nothing open
    a_rejected_closed: assert property (@(posedge clk) disable iff (!rst_n)
        block_rejected_reg |-> (block_remaining_reg == 7'd0))
        else $error("rejected block still has bytes open");

    // a read burst only starts when enough bytes are stored
    a_rx_burst_covered: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RX_RD) |-> (RSW'(rx_fill_reg) >= RSW'(rx_remaining_reg)))
        else $error("read burst exceeds stored bytes");

endmodule

// File: design/uart_tx_rx_ring_buffers.sv
// ----------------------------------------------------------------------------
// uart_tx_rx_ring_buffers
// Serial port buffer engine with a transmit ring and a receive ring.
// ----------------------------------------------------------------------------
// Input beats are classified and queued (two entries), then carried out one
// at a time by the ring engine. Host writes, received bytes, empty-ring
// transmitter-ready events and rejected or zero-length reads are answered
// from the idle state; a popped byte and each byte of a read first pass a
// read of the registered RAM port. Results leave through a registered
// output stage; the engine waits only while a result beat is held there,
// and the input stalls once both queue entries are taken. Ring contents are
// not cleared after reset; fill counters track what can be read.
// ----------------------------------------------------------------------------
module uart_tx_rx_ring_buffers #(
    parameter int TX_DEPTH = utrb_pkg::TX_DEPTH_DEF,
    parameter int RX_DEPTH = utrb_pkg::RX_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // data_byte [7:0], block_count [14:8], zero [15]
    input  logic [utrb_pkg::S_TDATA_W-1:0] s_tdata,
    // cmd [1:0], block_first [2]
    input  logic [utrb_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // tx_byte [7:0], tx_strobe [8], tx_irq_enable [9], rx_byte [17:10],
    // rx_byte_valid [18], rx_overflow [19], zero [23:20]
    output logic [utrb_pkg::M_TDATA_W-1:0] m_tdata,
    // status [1:0]
    output logic [utrb_pkg::M_TUSER_W-1:0] m_tuser,
    output logic                           m_tlast
);
    import utrb_pkg::*;

    logic op_valid;
    logic op_ready;
    op_t  op;
    res_t res;

    // accept and classify
    utrb_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .op_valid (op_valid),
        .op_ready (op_ready),
        .op       (op)
    );

    // ring engine
    utrb_back #(
        .TX_DEPTH (TX_DEPTH),
        .RX_DEPTH (RX_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (op_valid),
        .op_ready  (op_ready),
        .op        (op),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    // result beat packing
    assign m_tdata = {4'd0, res.rx_overflow, res.rx_byte_valid, res.rx_byte,
                      res.tx_irq_enable, res.tx_strobe, res.tx_byte};
    assign m_tuser = res.status;
    assign m_tlast = res.last;

endmodule
